FILE: rtl/tmcc_pkg.sv
// ----------------------------------------------------------------------------
// Tile map collision checker package
// Shared types, constants and the box border point helpers.
// ----------------------------------------------------------------------------
package tmcc_pkg;

	localparam int TILE_DIM_DEF = 32;
	localparam int MAX_COLS_DEF = 256;
	localparam int MAX_ROWS_DEF = 256;
	localparam int TILE_IDS_DEF = 64;

	localparam int COORD_W = 17;
	localparam int MAG_W = 16;
	localparam int TILE_W = 6;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;
	localparam int REG_IDX_W = 2;
	localparam int PT_IDX_W = 4;

	localparam logic [PT_IDX_W-1:0] BOX_LAST_PT = 4'd15;
	localparam logic [63:0] WALL_MASK_RST = 64'h0000_0000_0000_FFFE;

	localparam logic [REG_IDX_W-1:0] REG_MAP_COLS = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAP_ROWS = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_WALL_MASK = 2'd2;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_POINT = 2'd2,
		MODE_BOX   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		SPAN_A   = 3'd0,
		SPAN_Q1  = 3'd1,
		SPAN_MID = 3'd2,
		SPAN_Q3  = 3'd3,
		SPAN_B   = 3'd4
	} span_sel_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		span_sel_t xs;
		span_sel_t ys;
	} box_pt_t;

	typedef struct packed {
		logic [8:0]  map_cols;
		logic [8:0]  map_rows;
		logic [63:0] wall_mask;
	} cfg_t;

	// One point of the span a..b, with every division truncated toward zero.
	function automatic coord_t span_pt(coord_t a, coord_t b, span_sel_t sel);
		logic signed [17:0] d;
		logic signed [17:0] s;
		logic signed [19:0] d3;
		logic signed [17:0] q1;
		logic signed [17:0] mid;
		logic signed [19:0] q3;
		logic signed [19:0] r;
		d = 18'(b) - 18'(a);
		s = 18'(a) + 18'(b);
		d3 = (20'(d) <<< 1) + 20'(d);
		q1 = (d + (d[17] ? 18'sd3 : 18'sd0)) >>> 2;
		mid = (s + (s[17] ? 18'sd1 : 18'sd0)) >>> 1;
		q3 = (d3 + (d3[19] ? 20'sd3 : 20'sd0)) >>> 2;
		case (sel)
			SPAN_A:   r = 20'(a);
			SPAN_Q1:  r = 20'(a) + 20'(q1);
			SPAN_MID: r = 20'(mid);
			SPAN_Q3:  r = 20'(a) + q3;
			SPAN_B:   r = 20'(b);
			default:  r = 20'(a);
		endcase
		return coord_t'(r[COORD_W-1:0]);
	endfunction

	// Border walk: top edge, left edge, bottom edge, right edge.
	function automatic box_pt_t box_pt(logic [PT_IDX_W-1:0] k);
		box_pt_t p;
		case (k)
			4'd0:    p = '{SPAN_A, SPAN_A};
			4'd1:    p = '{SPAN_Q1, SPAN_A};
			4'd2:    p = '{SPAN_MID, SPAN_A};
			4'd3:    p = '{SPAN_Q3, SPAN_A};
			4'd4:    p = '{SPAN_B, SPAN_A};
			4'd5:    p = '{SPAN_A, SPAN_Q1};
			4'd6:    p = '{SPAN_A, SPAN_MID};
			4'd7:    p = '{SPAN_A, SPAN_Q3};
			4'd8:    p = '{SPAN_A, SPAN_B};
			4'd9:    p = '{SPAN_Q1, SPAN_B};
			4'd10:   p = '{SPAN_MID, SPAN_B};
			4'd11:   p = '{SPAN_Q3, SPAN_B};
			4'd12:   p = '{SPAN_B, SPAN_B};
			4'd13:   p = '{SPAN_B, SPAN_Q1};
			4'd14:   p = '{SPAN_B, SPAN_MID};
			default: p = '{SPAN_B, SPAN_Q3};
		endcase
		return p;
	endfunction

endpackage

FILE: rtl/tmcc_ifs.sv
// ----------------------------------------------------------------------------
// Tile map collision checker channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tmcc_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [9:0]         box_width;
	logic [9:0]         box_height;
	logic [5:0]         tile_in;

	modport source (output valid, mode, pos_x, pos_y, box_width, box_height, tile_in,
		input ready);
	modport sink (input valid, mode, pos_x, pos_y, box_width, box_height, tile_in,
		output ready);
endinterface

interface tmcc_out_if;
	logic       valid;
	logic       ready;
	logic [5:0] tile_out;
	logic       wall_hit;

	modport source (output valid, tile_out, wall_hit, input ready);
	modport sink (input valid, tile_out, wall_hit, output ready);
endinterface

FILE: rtl/tmcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Tile map collision checker configuration registers
// APB-style register file holding map size and wall mask.
// ----------------------------------------------------------------------------
module tmcc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tmcc_pkg::PADDR_W-1:0]     paddr,
	input  logic [tmcc_pkg::PDATA_W-1:0]     pwdata,
	output logic [tmcc_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready,
	output tmcc_pkg::cfg_t                   cfg
);

	logic [8:0]                        cols_q;
	logic [8:0]                        rows_q;
	logic [63:0]                       mask_q;
	logic [tmcc_pkg::REG_IDX_W-1:0]    reg_idx;
	logic                              wr_en;

	assign reg_idx = paddr[tmcc_pkg::PADDR_W-1:3];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= '0;
			rows_q <= '0;
			mask_q <= tmcc_pkg::WALL_MASK_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				tmcc_pkg::REG_MAP_COLS:  cols_q <= pwdata[8:0];
				tmcc_pkg::REG_MAP_ROWS:  rows_q <= pwdata[8:0];
				tmcc_pkg::REG_WALL_MASK: mask_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			tmcc_pkg::REG_MAP_COLS:  prdata = tmcc_pkg::PDATA_W'(cols_q);
			tmcc_pkg::REG_MAP_ROWS:  prdata = tmcc_pkg::PDATA_W'(rows_q);
			tmcc_pkg::REG_WALL_MASK: prdata = mask_q;
			default:                 prdata = '0;
		endcase
	end

	assign cfg = '{map_cols: cols_q, map_rows: rows_q, wall_mask: mask_q};

endmodule

FILE: rtl/tmcc_tile_ram.sv
// ----------------------------------------------------------------------------
// Tile map collision checker tile memory
// Single-port tile id store with registered read data.
// ----------------------------------------------------------------------------
module tmcc_tile_ram #(
	parameter int DEPTH  = tmcc_pkg::MAX_COLS_DEF * tmcc_pkg::MAX_ROWS_DEF,
	parameter int ADDR_W = 16
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ADDR_W-1:0]           addr,
	input  logic [tmcc_pkg::TILE_W-1:0] wdata,
	output logic [tmcc_pkg::TILE_W-1:0] rdata
);

	logic [tmcc_pkg::TILE_W-1:0] mem_q [DEPTH];
	logic [tmcc_pkg::TILE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/tmcc_seq.sv
// ----------------------------------------------------------------------------
// Tile map collision checker sequencer
// Walks the points of one request through a shared coordinate, divide,
// bounds and tile lookup pipeline, and holds the result register.
// ----------------------------------------------------------------------------
module tmcc_seq #(
	parameter int TILE_DIM  = tmcc_pkg::TILE_DIM_DEF,
	parameter int MAX_COLS  = tmcc_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS  = tmcc_pkg::MAX_ROWS_DEF,
	parameter int TILE_IDS  = tmcc_pkg::TILE_IDS_DEF,
	parameter int ADDR_W    = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tmcc_in_if.sink                     in_ch,
	tmcc_out_if.source                  out_ch,
	input  tmcc_pkg::cfg_t              cfg,
	output logic                        ram_we,
	output logic [ADDR_W-1:0]           ram_addr,
	output logic [tmcc_pkg::TILE_W-1:0] ram_wdata,
	input  logic [tmcc_pkg::TILE_W-1:0] ram_rdata
);

	localparam int MAG_W = tmcc_pkg::MAG_W;
	localparam int DIV_SH = MAG_W + $clog2(TILE_DIM);
	localparam int RECIP_W = DIV_SH + 1;
	localparam int PROD_W = MAG_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((longint'(1) << DIV_SH) +
		longint'(TILE_DIM) - 1) / longint'(TILE_DIM));

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SETUP  = 5'b00010,
		ST_ISSUE  = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t                              state_q;
	tmcc_pkg::mode_t                     mode_q;
	logic signed [15:0]                  x_q;
	logic signed [15:0]                  y_q;
	logic [9:0]                          w_q;
	logic [9:0]                          h_q;
	logic [tmcc_pkg::TILE_W-1:0]         tin_q;
	tmcc_pkg::coord_t                    left_q;
	tmcc_pkg::coord_t                    right_q;
	tmcc_pkg::coord_t                    top_q;
	tmcc_pkg::coord_t                    bot_q;
	logic [tmcc_pkg::PT_IDX_W-1:0]       k_q;
	logic [tmcc_pkg::PT_IDX_W-1:0]       k_last;

	logic                                v_s1, v_s2, v_s3, v_s4, v_s5;
	tmcc_pkg::coord_t                    wx_s1, wy_s1;
	logic                                negx_s2, negy_s2;
	logic [MAG_W-1:0]                    magx_s2, magy_s2;
	logic                                negx_s3, negy_s3;
	logic [MAG_W-1:0]                    qx_s3, qy_s3;
	logic                                onmap_s4;
	logic                                we_s4;
	logic [ADDR_W-1:0]                   addr_s4;
	logic                                onmap_s5;

	logic [tmcc_pkg::TILE_W-1:0]         tile_acc_q;
	logic                                hit_acc_q;
	logic                                out_valid_q;
	logic [tmcc_pkg::TILE_W-1:0]         tile_out_q;
	logic                                wall_hit_q;

	logic                                in_rdy;
	logic                                in_fire;
	logic                                out_load;
	logic                                pipe_busy;
	tmcc_pkg::box_pt_t                   bp;
	tmcc_pkg::coord_t                    cx, cy;
	tmcc_pkg::coord_t                    hw, hh;
	tmcc_pkg::coord_t                    absx, absy;
	logic [PROD_W-1:0]                   prodx, prody;
	logic                                inx, iny;
	logic                                pt_wall;

	assign in_rdy = (state_q == ST_IDLE);
	assign in_fire = in_ch.valid && in_rdy;
	assign in_ch.ready = in_rdy;
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_ch.ready);
	assign k_last = (mode_q == tmcc_pkg::MODE_BOX) ? tmcc_pkg::BOX_LAST_PT : '0;

	assign hw = tmcc_pkg::coord_t'({1'b0, w_q[9:1]});
	assign hh = tmcc_pkg::coord_t'({1'b0, h_q[9:1]});

	always_comb begin
		bp = tmcc_pkg::box_pt(k_q);
		if (mode_q == tmcc_pkg::MODE_BOX) begin
			cx = tmcc_pkg::span_pt(left_q, right_q, bp.xs);
			cy = tmcc_pkg::span_pt(top_q, bot_q, bp.ys);
		end else begin
			cx = tmcc_pkg::coord_t'(x_q);
			cy = tmcc_pkg::coord_t'(y_q);
		end
	end

	assign absx = wx_s1[tmcc_pkg::COORD_W-1] ? -wx_s1 : wx_s1;
	assign absy = wy_s1[tmcc_pkg::COORD_W-1] ? -wy_s1 : wy_s1;

	assign prodx = PROD_W'(magx_s2) * PROD_W'(RECIP);
	assign prody = PROD_W'(magy_s2) * PROD_W'(RECIP);

	assign inx = !(negx_s3 && (qx_s3 != '0)) && (qx_s3 < MAG_W'(cfg.map_cols)) &&
		(qx_s3 < MAG_W'(MAX_COLS));
	assign iny = !(negy_s3 && (qy_s3 != '0)) && (qy_s3 < MAG_W'(cfg.map_rows)) &&
		(qy_s3 < MAG_W'(MAX_ROWS));

	assign pt_wall = !onmap_s5 || ({1'b0, ram_rdata} >= 7'(TILE_IDS)) ||
		cfg.wall_mask[ram_rdata];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					k_q <= '0;
					state_q <= ST_ISSUE;
				end
				ST_ISSUE: begin
					k_q <= k_q + 1'b1;
					if (k_q == k_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q <= tmcc_pkg::mode_t'(in_ch.mode);
			x_q <= in_ch.pos_x;
			y_q <= in_ch.pos_y;
			w_q <= in_ch.box_width;
			h_q <= in_ch.box_height;
			tin_q <= in_ch.tile_in;
		end
		if (state_q == ST_SETUP) begin
			left_q <= tmcc_pkg::coord_t'(x_q) - hw;
			right_q <= tmcc_pkg::coord_t'(x_q) + hw - tmcc_pkg::coord_t'(1);
			top_q <= tmcc_pkg::coord_t'(y_q) - hh;
			bot_q <= tmcc_pkg::coord_t'(y_q) + hh - tmcc_pkg::coord_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			we_s4 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_ISSUE);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			we_s4 <= v_s3 && inx && iny && (mode_q == tmcc_pkg::MODE_WRITE);
		end
	end

	always_ff @(posedge clk) begin
		wx_s1 <= cx;
		wy_s1 <= cy;
		negx_s2 <= wx_s1[tmcc_pkg::COORD_W-1];
		negy_s2 <= wy_s1[tmcc_pkg::COORD_W-1];
		magx_s2 <= absx[MAG_W-1:0];
		magy_s2 <= absy[MAG_W-1:0];
		negx_s3 <= negx_s2;
		negy_s3 <= negy_s2;
		if (mode_q == tmcc_pkg::MODE_WRITE || mode_q == tmcc_pkg::MODE_READ) begin
			qx_s3 <= magx_s2;
			qy_s3 <= magy_s2;
		end else begin
			qx_s3 <= prodx[DIV_SH +: MAG_W];
			qy_s3 <= prody[DIV_SH +: MAG_W];
		end
		onmap_s4 <= inx && iny;
		addr_s4 <= ADDR_W'(qy_s3) * ADDR_W'(MAX_COLS) + ADDR_W'(qx_s3);
		onmap_s5 <= onmap_s4;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			tile_acc_q <= '0;
			hit_acc_q <= 1'b0;
		end else if (v_s5) begin
			if (mode_q == tmcc_pkg::MODE_READ && onmap_s5) begin
				tile_acc_q <= ram_rdata;
			end
			if (mode_q == tmcc_pkg::MODE_POINT || mode_q == tmcc_pkg::MODE_BOX) begin
				hit_acc_q <= hit_acc_q | pt_wall;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			tile_out_q <= tile_acc_q;
			wall_hit_q <= hit_acc_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.tile_out = tile_out_q;
	assign out_ch.wall_hit = wall_hit_q;

	assign ram_we = we_s4;
	assign ram_addr = addr_s4;
	assign ram_wdata = tin_q;

`ifndef SYNTHESIS
	a_ready_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_rdy |-> !pipe_busy)
		else $error("Request taken while the point pipeline is busy.");

	a_write_mode: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (mode_q == tmcc_pkg::MODE_WRITE))
		else $error("Tile memory written outside a tile write request.");

	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_SETUP))
		else $error("Accepted request did not start its setup step.");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("Result appeared without a finished request.");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> (k_q <= k_last))
		else $error("Point counter ran past the last point.");
`endif

endmodule

FILE: rtl/tile_map_collision_checker_top.sv
// ----------------------------------------------------------------------------
// Tile map collision checker
// Tile id map with tile write, tile read, point check and box border check.
//
//   Channel   Dir   Handshake           Payload
//   in_ch     in    valid/ready         mode, pos_x, pos_y, box_width,
//                                       box_height, tile_in
//   out_ch    out   valid/ready         tile_out, wall_hit
//   apb       in    psel/penable/pready map_cols, map_rows, wall_mask
//
// A box check walks its sixteen border points, one lookup per cycle through
// the shared divide and bounds pipeline into the single-port tile memory.
// One request is in work at a time; a finished result waits in the output
// register while the next request is accepted and processed.
// Reset clears control state and the configuration registers; the tile memory is not cleared.
// ----------------------------------------------------------------------------
module tile_map_collision_checker_top #(
	parameter int TILE_DIM  = tmcc_pkg::TILE_DIM_DEF,
	parameter int MAX_COLS  = tmcc_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS  = tmcc_pkg::MAX_ROWS_DEF,
	parameter int TILE_IDS  = tmcc_pkg::TILE_IDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	tmcc_in_if.sink                      in_ch,
	tmcc_out_if.source                   out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tmcc_pkg::PADDR_W-1:0] paddr,
	input  logic [tmcc_pkg::PDATA_W-1:0] pwdata,
	output logic [tmcc_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	tmcc_pkg::cfg_t               cfg;
	logic                         ram_we;
	logic [ADDR_W-1:0]            ram_addr;
	logic [tmcc_pkg::TILE_W-1:0]  ram_wdata;
	logic [tmcc_pkg::TILE_W-1:0]  ram_rdata;

	tmcc_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tmcc_seq #(
		.TILE_DIM  (TILE_DIM),
		.MAX_COLS  (MAX_COLS),
		.MAX_ROWS  (MAX_ROWS),
		.TILE_IDS  (TILE_IDS),
		.ADDR_W    (ADDR_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg       (cfg),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

	tmcc_tile_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_tile_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule
